// ----- sv/gchs_pkg.sv -----
// Package: shared constants and types for the grid cell height statistics block.
`default_nettype none
package gchs_pkg;
    localparam int CELL_COUNT_DEF = 4096;
    localparam int IDX_W     = 13;
    localparam int COORD_W   = 24;
    localparam int CNT_W     = 16;
    localparam int VAR_W     = 63;
    localparam int DIST_W    = 49;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_CELLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_Y  = 2'd2;

    localparam logic FUNC_NEW_SCAN  = 1'b0;
    localparam logic FUNC_ADD_POINT = 1'b1;

    localparam logic [1:0] ST_MERGED  = 2'd0;
    localparam logic [1:0] ST_FIRST   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [CNT_W-1:0] MAX_COUNT = 16'hFFFF;

    typedef struct packed {
        logic                      func;
        logic [IDX_W-1:0]          cell_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic [1:0]                status;
        logic [IDX_W-1:0]          cell_out;
        logic [CNT_W-1:0]          point_count;
        logic signed [COORD_W-1:0] height_min;
        logic signed [COORD_W-1:0] height_max;
        logic signed [COORD_W-1:0] height_mean;
        logic [VAR_W-1:0]          variance_sum;
        logic [DIST_W-1:0]         distance_squared;
    } t_result;
endpackage
`default_nettype wire

// ----- sv/gchs_if.sv -----
// Interfaces: valid/ready channels for points and results.
`default_nettype none
interface gchs_point_if;
    logic valid;
    logic ready;
    gchs_pkg::t_point payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gchs_result_if;
    logic valid;
    logic ready;
    gchs_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/grid_cell_height_statistics.sv -----
// Top level: per-cell height statistics kept in a synchronous memory.
// States to result valid: merged point S_RD, S_EVAL, S_MUL, S_DIV (42-step serial mean
// divider), S_VAR1, S_VAR2, S_OUT, S_WR; first point S_RD, S_EVAL, S_DIST, S_WR; saturated
// cell S_RD, S_EVAL, S_WR; outside point at accept. One item at a time: the next is taken
// once any result is transferred. New-scan items advance the epoch; every 255th sweeps all
// tags. Reset (synchronous, active low) clears control, sets epoch to one, sweeps all tags.
`default_nettype none
module grid_cell_height_statistics #(
    parameter int CELL_COUNT = gchs_pkg::CELL_COUNT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [gchs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [gchs_pkg::CFG_W-1:0]          i_cfg_data,
    gchs_point_if.sink                         point_in,
    gchs_result_if.source                      result_out
);
    localparam int AW = $clog2(CELL_COUNT);
    localparam int EW = 8;   // epoch width: valid marks via epoch compare
    localparam int DW = 42;  // dividend width: |mean*n+z| < 2^41
    localparam int QW = 24;
    localparam int DCW = $clog2(DW + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_EVAL = 4'd2, S_MUL = 4'd3,
                           S_DIV = 4'd4, S_VAR1 = 4'd5, S_VAR2 = 4'd6, S_WR = 4'd7,
                           S_OUT = 4'd8, S_DIST = 4'd9, S_CLR = 4'd10;

    // Configuration.
    logic [gchs_pkg::IDX_W-1:0]          r_map_cells;
    logic signed [gchs_pkg::COORD_W-1:0] r_sensor_x, r_sensor_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cells <= gchs_pkg::IDX_W'(4096);
            r_sensor_x  <= '0;
            r_sensor_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gchs_pkg::CFG_MAP_CELLS: r_map_cells <= i_cfg_data[gchs_pkg::IDX_W-1:0];
                gchs_pkg::CFG_SENSOR_X:  r_sensor_x  <= i_cfg_data;
                gchs_pkg::CFG_SENSOR_Y:  r_sensor_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cell memory: one wide word per cell, epoch tag marks validity.
    localparam int MW = EW + gchs_pkg::CNT_W + 3 * gchs_pkg::COORD_W
                        + gchs_pkg::VAR_W + gchs_pkg::DIST_W;
    typedef struct packed {
        logic [EW-1:0]                       epoch;
        logic [gchs_pkg::CNT_W-1:0]          cnt;
        logic signed [gchs_pkg::COORD_W-1:0] mn;
        logic signed [gchs_pkg::COORD_W-1:0] mx;
        logic signed [gchs_pkg::COORD_W-1:0] mean;
        logic [gchs_pkg::VAR_W-1:0]          var_s;
        logic [gchs_pkg::DIST_W-1:0]         dsq;
    } t_cell;
    logic [MW-1:0] mem [CELL_COUNT];
    logic [MW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_cell         r_cell;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= r_cell;
        r_rd <= mem[mem_addr];
    end

    // Epoch: a new scan bumps it; on wrap every entry is swept back to tag zero.
    logic [EW-1:0] r_epoch;
    logic [AW:0]   r_clr;

    logic [3:0]  r_state;
    gchs_pkg::t_point  r_pt;
    gchs_pkg::t_result r_res;
    logic        r_oval;
    logic [AW-1:0] r_idx;

    // Divider and multiplier datapath.
    logic signed [49:0] r_prod;       // mean*n, then variance product
    logic [DW-1:0]      r_rem_num;    // |dividend| shifted
    logic [16:0]        r_den;
    logic [16:0]        r_rem;
    logic [DW-1:0]      r_quo;
    logic               r_neg;
    logic [DCW-1:0]     r_dcnt;
    logic signed [QW:0] r_nm;
    logic signed [49:0] r_d1;

    wire [AW:0] limit = (32'(r_map_cells) < CELL_COUNT) ? (AW+1)'(r_map_cells)
                                                        : (AW+1)'(CELL_COUNT);
    wire        outside = 32'(point_in.payload.cell_index) >= 32'(limit);

    assign point_in.ready = (r_state == S_IDLE) && !r_oval;
    wire   in_xfer = point_in.valid && point_in.ready;
    assign result_out.valid   = r_oval;
    assign result_out.payload = r_res;

    t_cell rc;
    assign rc = t_cell'(r_rd);
    wire        hit = (rc.epoch == r_epoch);
    wire signed [24:0] dxz = 25'(r_pt.point_x) - 25'(r_sensor_x);
    wire signed [24:0] dyz = 25'(r_pt.point_y) - 25'(r_sensor_y);
    wire [23:0] ax = dxz[24] ? 24'(-dxz) : dxz[23:0];
    wire [23:0] ay = dyz[24] ? 24'(-dyz) : dyz[23:0];
    wire [17:0] trial = {r_rem, r_rem_num[DW-1]};
    wire signed [25:0] dz_old = 26'(r_pt.point_z) - 26'(r_cell.mean);
    wire signed [25:0] dz_new = 26'(r_pt.point_z) - 26'(r_nm);
    wire [62:0] pmag = r_prod[49] ? 63'(-r_prod) : 63'(r_prod);
    wire [63:0] vsum = 64'(r_cell.var_s) + 64'(pmag);

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_idx;
        if (r_state == S_IDLE) mem_addr = AW'(point_in.payload.cell_index);
        if (r_state == S_WR) mem_we = 1'b1;
        if (r_state == S_CLR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        t_cell             cell_n;
        gchs_pkg::t_result res_n;
        logic signed [42:0] num;
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_oval  <= 1'b0;
            r_epoch <= EW'(1);
            r_clr   <= '0;
            r_cell  <= '0;
        end else begin
            if (result_out.valid && result_out.ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        res_n = '0;
                        res_n.cell_out = point_in.payload.cell_index;
                        r_pt  <= point_in.payload;
                        r_idx <= AW'(point_in.payload.cell_index);
                        if (point_in.payload.func == gchs_pkg::FUNC_NEW_SCAN) begin
                            // Advance the epoch; on wrap sweep all tags.
                            if (r_epoch == '1) begin
                                r_epoch <= EW'(1);
                                r_clr   <= '0;
                                r_cell  <= '0;
                                r_state <= S_CLR;
                            end else begin
                                r_epoch <= r_epoch + EW'(1);
                            end
                        end else if (outside) begin
                            res_n.status = gchs_pkg::ST_OUTSIDE;
                            r_oval <= 1'b1;
                        end else begin
                            r_state <= S_RD;
                        end
                        r_res <= res_n;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    cell_n = rc;
                    if (!hit) begin
                        cell_n.epoch = r_epoch;
                        cell_n.cnt   = 16'd1;
                        cell_n.mn    = r_pt.point_z;
                        cell_n.mx    = r_pt.point_z;
                        cell_n.mean  = r_pt.point_z;
                        cell_n.var_s = '0;
                        r_d1  <= 50'(ax * ax);
                        r_res.status <= gchs_pkg::ST_FIRST;
                        r_state <= S_DIST;
                    end else begin
                        if (r_pt.point_z > rc.mx) cell_n.mx = r_pt.point_z;
                        if (r_pt.point_z < rc.mn) cell_n.mn = r_pt.point_z;
                        r_res.status <= gchs_pkg::ST_MERGED;
                        r_prod <= 50'(rc.mean * $signed({1'b0, rc.cnt}));
                        r_state <= (rc.cnt == gchs_pkg::MAX_COUNT) ? S_WR : S_MUL;
                    end
                    r_cell <= cell_n;
                end
                S_DIST: begin
                    r_cell.dsq <= (50'(r_d1) + 50'(ay * ay) > 50'({49{1'b1}}))
                                  ? {49{1'b1}} : 49'(50'(r_d1) + 50'(ay * ay));
                    r_state <= S_WR;
                end
                S_MUL: begin
                    // Sign-magnitude restoring division of mean*n+z by n+1.
                    num = 43'(r_prod) + 43'(r_pt.point_z);
                    r_neg     <= num[42];
                    r_rem_num <= num[42] ? DW'(-num) : DW'(num);
                    r_den     <= 17'(r_cell.cnt) + 17'd1;
                    r_rem     <= '0;
                    r_quo     <= '0;
                    r_dcnt    <= DCW'(DW);
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_rem_num <= r_rem_num << 1;
                    if (trial >= 18'(r_den)) begin
                        r_rem <= 17'(trial - 18'(r_den));
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[16:0];
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) r_state <= S_VAR1;
                end
                S_VAR1: begin
                    r_nm <= r_neg ? -$signed((QW+1)'(r_quo)) : $signed((QW+1)'(r_quo));
                    r_state <= S_VAR2;
                end
                S_VAR2: begin
                    r_prod  <= 50'(dz_old * dz_new);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    cell_n = r_cell;
                    if (!r_prod[49])
                        cell_n.var_s = vsum[63] ? {63{1'b1}} : vsum[62:0];
                    else
                        cell_n.var_s = (pmag > r_cell.var_s) ? '0
                                       : r_cell.var_s - pmag;
                    cell_n.mean = r_nm[QW-1:0];
                    cell_n.cnt  = r_cell.cnt + 16'd1;
                    r_cell  <= cell_n;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_res <= {r_res.status, r_res.cell_out, r_cell.cnt, r_cell.mn,
                              r_cell.mx, r_cell.mean, r_cell.var_s, r_cell.dsq};
                    r_oval  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    r_cell <= '0;
                    if (r_clr == (AW+1)'(CELL_COUNT - 1)) r_state <= S_IDLE;
                    r_clr <= r_clr + (AW+1)'(1);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !point_in.ready) else $error("accept while busy");
    a_wr_leads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> r_oval) else $error("write without result");
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0) else $error("epoch zero");
`endif
endmodule
`default_nettype wire

// ----- tb/grid_cell_height_statistics_test.sv -----
// Testbench for grid_cell_height_statistics: directed table, random points, predictor.
`timescale 1ns / 100ps
`default_nettype none
module grid_cell_height_statistics_test;

    localparam int STORE_DEPTH = 4096;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1550;
    localparam logic [62:0] VAR_TOP  = {63{1'b1}};
    localparam logic [48:0] DIST_TOP = {49{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [gchs_pkg::CFG_IDX_W-1:0] i_cfg_index = gchs_pkg::CFG_MAP_CELLS;
    logic [gchs_pkg::CFG_W-1:0] i_cfg_data = '0;

    gchs_point_if point_ch ();
    gchs_result_if result_ch ();

    grid_cell_height_statistics dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .point_in    (point_ch.sink),
        .result_out  (result_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the cell stores and registers.
    logic [12:0]        grid_cells;
    logic signed [23:0] sensor_pos_x, sensor_pos_y;
    bit                 cell_seen [STORE_DEPTH];
    logic [15:0]        cell_points [STORE_DEPTH];
    logic signed [23:0] cell_low [STORE_DEPTH];
    logic signed [23:0] cell_high [STORE_DEPTH];
    logic signed [23:0] cell_avg [STORE_DEPTH];
    logic [62:0]        cell_spread [STORE_DEPTH];
    logic [48:0]        cell_range [STORE_DEPTH];

    gchs_pkg::t_result pending_stats [$];
    int  error_count = 0;
    bit  quiet_phase = 1'b0;
    int  idle_cycles = 0;

    // Work out the cell record after one point and update the model state.
    function automatic bit merge_point(input gchs_pkg::t_point p,
                                       output gchs_pkg::t_result r);
        int unsigned bound;
        longint dx, dy, n, old_avg, new_avg, prod;
        logic [63:0] dist_sum;
        logic [62:0] v;
        r = '0;
        if (p.func == gchs_pkg::FUNC_NEW_SCAN) begin
            foreach (cell_seen[k]) cell_seen[k] = 1'b0;
            return 1'b0;
        end
        bound = (grid_cells < STORE_DEPTH) ? grid_cells : STORE_DEPTH;
        r.cell_out = p.cell_index;
        if (p.cell_index >= bound) begin
            r.status = gchs_pkg::ST_OUTSIDE;
            return 1'b1;
        end
        if (!cell_seen[p.cell_index]) begin
            dx = longint'(p.point_x) - longint'(sensor_pos_x);
            dy = longint'(p.point_y) - longint'(sensor_pos_y);
            dist_sum = 64'(dx * dx) + 64'(dy * dy);
            cell_seen[p.cell_index]   = 1'b1;
            cell_points[p.cell_index] = 16'd1;
            cell_low[p.cell_index]    = p.point_z;
            cell_high[p.cell_index]   = p.point_z;
            cell_avg[p.cell_index]    = p.point_z;
            cell_spread[p.cell_index] = '0;
            cell_range[p.cell_index]  = (dist_sum > 64'(DIST_TOP)) ? DIST_TOP
                                                                   : dist_sum[48:0];
            r.status = gchs_pkg::ST_FIRST;
        end else begin
            if (p.point_z > cell_high[p.cell_index]) cell_high[p.cell_index] = p.point_z;
            if (p.point_z < cell_low[p.cell_index]) cell_low[p.cell_index] = p.point_z;
            if (cell_points[p.cell_index] < gchs_pkg::MAX_COUNT) begin
                n = cell_points[p.cell_index];
                old_avg = cell_avg[p.cell_index];
                // SystemVerilog division truncates toward zero, as required.
                new_avg = (old_avg * n + longint'(p.point_z)) / (n + 1);
                prod = (longint'(p.point_z) - old_avg) * (longint'(p.point_z) - new_avg);
                v = cell_spread[p.cell_index];
                if (prod >= 0)
                    v = (64'(prod) > 64'(VAR_TOP - v)) ? VAR_TOP : v + 63'(prod);
                else
                    v = (64'(-prod) > 64'(v)) ? '0 : v - 63'(-prod);
                cell_points[p.cell_index] = 16'(n + 1);
                cell_avg[p.cell_index]    = 24'(new_avg);
                cell_spread[p.cell_index] = v;
            end
            r.status = gchs_pkg::ST_MERGED;
        end
        r.point_count      = cell_points[p.cell_index];
        r.height_min       = cell_low[p.cell_index];
        r.height_max       = cell_high[p.cell_index];
        r.height_mean      = cell_avg[p.cell_index];
        r.variance_sum     = cell_spread[p.cell_index];
        r.distance_squared = cell_range[p.cell_index];
        return 1'b1;
    endfunction

    // Idle with a chance of about 19 in 100, except during the quiet stretch.
    function automatic bit take_gap();
        return !quiet_phase && ($urandom_range(99) < 19);
    endfunction

    // Result side: random stall, compare at the rising edge.
    initial result_ch.ready = 1'b0;
    always @(negedge i_clk) result_ch.ready <= !take_gap();

    always @(posedge i_clk) begin
        gchs_pkg::t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result %p", $time, result_ch.payload);
                error_count++;
            end else begin
                want = pending_stats.pop_front();
                if (result_ch.payload.status !== want.status ||
                    result_ch.payload.cell_out !== want.cell_out ||
                    result_ch.payload.point_count !== want.point_count ||
                    result_ch.payload.height_min !== want.height_min ||
                    result_ch.payload.height_max !== want.height_max ||
                    result_ch.payload.height_mean !== want.height_mean ||
                    result_ch.payload.variance_sum !== want.variance_sum ||
                    result_ch.payload.distance_squared !== want.distance_squared) begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, want, result_ch.payload);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive one point, predict it, and hold until the transfer.
    task automatic send_point(input gchs_pkg::t_point p);
        gchs_pkg::t_result r;
        while (take_gap()) begin
            point_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        point_ch.payload <= p;
        point_ch.valid   <= 1'b1;
        if (merge_point(p, r)) pending_stats.push_back(r);
        @(posedge i_clk);
        while (!point_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for all results, then let any scan clear finish before a write.
    task automatic drain();
        point_ch.valid <= 1'b0;
        while (pending_stats.size() != 0 || !point_ch.ready) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gchs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gchs_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gchs_pkg::CFG_MAP_CELLS: grid_cells   = val[12:0];
            gchs_pkg::CFG_SENSOR_X:  sensor_pos_x = val;
            default:                 sensor_pos_y = val;
        endcase
    endtask

    function automatic gchs_pkg::t_point make_point(input logic [12:0] idx,
                                                    input logic [23:0] x,
                                                    input logic [23:0] y,
                                                    input logic [23:0] z);
        gchs_pkg::t_point p;
        p.func = gchs_pkg::FUNC_ADD_POINT;
        p.cell_index = idx;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // Random point: mostly small cell sets so cells collect many points.
    task automatic random_point(input int span);
        gchs_pkg::t_point p;
        logic [23:0] z;
        p = make_point('0, 24'($urandom), 24'($urandom), 24'($urandom));
        if ($urandom_range(9) == 0) begin
            p.cell_index = 13'($urandom);
        end else begin
            p.cell_index = 13'($urandom_range(span - 1));
        end
        case ($urandom_range(3))
            0: z = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            1: z = 24'($signed($urandom_range(4000)) - 2000);
            default: z = 24'($urandom);
        endcase
        p.point_z = z;
        if ($urandom_range(199) == 0) p.func = gchs_pkg::FUNC_NEW_SCAN;
        send_point(p);
    endtask

    typedef struct {
        gchs_pkg::t_point   pt;
        bit                 known;
        gchs_pkg::t_result  want;
    } t_directed_row;

    initial begin
        t_directed_row rows [$];
        t_directed_row row;
        gchs_pkg::t_result r;
        int cells;

        point_ch.valid = 1'b0;
        point_ch.payload = '0;
        grid_cells = 13'd4096;
        sensor_pos_x = '0;
        sensor_pos_y = '0;
        foreach (cell_seen[k]) cell_seen[k] = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: extremes, first and merge, outside, new scan.
        row.known = 1'b1;
        row.pt = make_point(13'd0, 24'h000000, 24'h000000, 24'h000100);
        row.want = '{gchs_pkg::ST_FIRST, 13'd0, 16'd1, 24'h000100, 24'h000100,
                     24'h000100, '0, '0};
        rows.push_back(row);
        row.pt = make_point(13'd4096, 24'h0, 24'h0, 24'h0);
        row.want = '{gchs_pkg::ST_OUTSIDE, 13'd4096, '0, '0, '0, '0, '0, '0};
        rows.push_back(row);
        row.pt = make_point(13'h1FFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        row.want = '{gchs_pkg::ST_OUTSIDE, 13'h1FFF, '0, '0, '0, '0, '0, '0};
        rows.push_back(row);
        row.known = 1'b0;
        row.pt = make_point(13'd4095, 24'h800000, 24'h800000, 24'h800000);
        rows.push_back(row);
        row.pt = make_point(13'd4095, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        rows.push_back(row);
        row.pt = make_point(13'd4095, 24'h0, 24'h0, 24'h800000);
        rows.push_back(row);
        row.pt = make_point(13'd0, 24'h0, 24'h0, 24'hFFFF00);
        rows.push_back(row);
        row.pt = make_point(13'd0, 24'h0, 24'h0, 24'h000000);
        row.pt.func = gchs_pkg::FUNC_NEW_SCAN;
        rows.push_back(row);
        row.pt = make_point(13'd0, 24'h123456, 24'hABCDEF, 24'h000500);
        rows.push_back(row);
        row.pt = make_point(13'd4095, 24'h0, 24'h0, 24'h800000);
        rows.push_back(row);

        foreach (rows[i]) begin
            if (rows[i].known) begin
                void'(merge_point(rows[i].pt, r));
                pending_stats.push_back(rows[i].want);
                while (take_gap()) begin
                    point_ch.valid <= 1'b0;
                    @(negedge i_clk);
                end
                point_ch.payload <= rows[i].pt;
                point_ch.valid   <= 1'b1;
                @(posedge i_clk);
                while (!point_ch.ready) @(posedge i_clk);
                @(negedge i_clk);
            end else begin
                send_point(rows[i].pt);
            end
        end
        drain();

        // Random part across several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'd1);
                    write_reg(gchs_pkg::CFG_SENSOR_X, 24'h7FFFFF);
                    write_reg(gchs_pkg::CFG_SENSOR_Y, 24'h800000);
                end
                1: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'h1FFF);
                    write_reg(gchs_pkg::CFG_SENSOR_X, 24'h800000);
                    write_reg(gchs_pkg::CFG_SENSOR_Y, 24'h7FFFFF);
                end
                2: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'd0);
                end
                3: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'd16);
                    write_reg(gchs_pkg::CFG_SENSOR_X, 24'(-24'sd1));
                    write_reg(gchs_pkg::CFG_SENSOR_Y, 24'd0);
                end
                4: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'd4096);
                    write_reg(gchs_pkg::CFG_SENSOR_X, 24'($urandom));
                    write_reg(gchs_pkg::CFG_SENSOR_Y, 24'($urandom));
                end
                default: begin
                    write_reg(gchs_pkg::CFG_MAP_CELLS, 24'($urandom_range(4096, 1)));
                    quiet_phase = 1'b1;
                end
            endcase
            cells = (phase == 2) ? 8 : (($urandom_range(1)) ? 4 : 64);
            for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
                if (phase == 4 && i == 100) cells = 4096;
                random_point(cells);
            end
            drain();
            quiet_phase = 1'b0;
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/gchs_pkg.sv
sv/gchs_if.sv
sv/grid_cell_height_statistics.sv
tb/grid_cell_height_statistics_test.sv
